@@ rtl/i2cmtq_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master transaction queue package
// Shared request and result types, state encoding and bus status codes.
// ----------------------------------------------------------------------------
package i2cmtq_pkg;

  // Default storage sizes
  localparam int DEF_QUEUE_DEPTH   = 32;
  localparam int DEF_PAYLOAD_DEPTH = 64;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_QWRITE = 2'd0,
    REQ_QREAD  = 2'd1,
    REQ_PUSH   = 2'd2,
    REQ_EVENT  = 2'd3
  } req_t;

  // Bus engine status codes (low three bits are ignored on compare).
  // Arbitration lost, read address NACK and the no-info code fall into the
  // fault path together with every other unlisted code.
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_RSTART       = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
  localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
  localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
  localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Source of the byte loaded into the engine data register
  typedef enum logic [1:0] {
    WSEL_NONE = 2'd0,
    WSEL_ADDR = 2'd1,
    WSEL_PAY  = 2'd2
  } wsel_t;

  // Input request
  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] dev_addr;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
    logic [7:0] bus_status;
  } in_req_t;

  // Result
  typedef struct packed {
    logic       accepted;
    logic       issue_command;
    logic       cmd_start;
    logic       cmd_stop;
    logic       cmd_ack;
    logic       write_data_valid;
    logic [7:0] write_data;
    logic       read_valid;
    logic [7:0] read_data;
    logic       transaction_done;
    logic       fault;
  } out_res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  load;
    logic  commit;
    logic  desc_push;
    logic  rem_load;
    logic  pay_push;
    logic  pay_pop;
    logic  rem_dec;
    logic  head_finish;
    logic  accepted;
    logic  issue;
    logic  start;
    logic  stop;
    logic  ack;
    wsel_t wsel;
    logic  rvalid;
    logic  done;
    logic  fault;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    req_t       req;
    logic [4:0] code;
    logic       len_zero;
    logic       desc_empty;
    logic       desc_full;
    logic       desc_last;
    logic       pay_empty;
    logic       pay_full;
    logic       head_rd;
    logic       rem_le1;
    logic       rem_le2;
  } status_t;

endpackage

@@ rtl/i2cmtq_dp.sv @@
// ----------------------------------------------------------------------------
// I2C master transaction queue datapath
// Request register, descriptor and payload memories, indices, counters and
// the result register. Queue state and the result change only on a commit command.
// ----------------------------------------------------------------------------
module i2cmtq_dp
  import i2cmtq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
  parameter int PAYLOAD_DEPTH = DEF_PAYLOAD_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_data,
  input  cmd_t     cmd,
  output status_t  st,
  output out_res_t out_data
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int PC = $clog2(PAYLOAD_DEPTH + 1);

  // Descriptor word: length, read flag, address
  logic [15:0] desc_mem [QUEUE_DEPTH];
  logic [7:0]  pay_mem  [PAYLOAD_DEPTH];

  in_req_t     item_r;
  logic [15:0] dhead_q_r;
  logic [15:0] dnext_q_r;
  logic [7:0]  pay_q_r;
  out_res_t    out_r;

  logic [QW-1:0] head_idx_r, head_idx_nxt;
  logic [QW-1:0] tail_idx_r, tail_idx_nxt;
  logic [QC-1:0] dcnt_r, dcnt_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [PW-1:0] prd_idx_r, prd_idx_nxt;
  logic [PW-1:0] pwr_idx_r, pwr_idx_nxt;
  logic [PC-1:0] pcnt_r, pcnt_nxt;
  logic [QW-1:0] head_inc;
  logic [QW-1:0] tail_inc;
  logic [PW-1:0] prd_inc;
  logic [PW-1:0] pwr_inc;
  out_res_t      out_nxt;

  // Wrapping index increments
  assign head_inc = (head_idx_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_idx_r + 1'b1;
  assign tail_inc = (tail_idx_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_idx_r + 1'b1;
  assign prd_inc  = (prd_idx_r == PW'(PAYLOAD_DEPTH - 1)) ? '0 : prd_idx_r + 1'b1;
  assign pwr_inc  = (pwr_idx_r == PW'(PAYLOAD_DEPTH - 1)) ? '0 : pwr_idx_r + 1'b1;

  // Capture the request and read head, next head and payload entries
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r    <= in_data;
      dhead_q_r <= desc_mem[head_idx_r];
      dnext_q_r <= desc_mem[head_inc];
      pay_q_r   <= pay_mem[prd_idx_r];
    end
  end

  // Write the memories on commit
  always_ff @(posedge clk) begin
    if (cmd.commit && cmd.desc_push) begin
      desc_mem[tail_idx_r] <= {item_r.byte_count, item_r.req_type[0],
                               item_r.dev_addr};
    end
    if (cmd.commit && cmd.pay_push) begin
      pay_mem[pwr_idx_r] <= item_r.data_byte;
    end
  end

  // Status toward the controller
  always_comb begin
    st.req        = req_t'(item_r.req_type);
    st.code       = item_r.bus_status[7:3];
    st.len_zero   = (item_r.byte_count == 8'd0);
    st.desc_empty = (dcnt_r == '0);
    st.desc_full  = (dcnt_r == QC'(QUEUE_DEPTH));
    st.desc_last  = (dcnt_r == QC'(1));
    st.pay_empty  = (pcnt_r == '0);
    st.pay_full   = (pcnt_r == PC'(PAYLOAD_DEPTH));
    st.head_rd    = dhead_q_r[7];
    st.rem_le1    = (rem_r <= 8'd1);
    st.rem_le2    = (rem_r <= 8'd2);
  end

  // Next queue and FIFO state
  always_comb begin
    head_idx_nxt = head_idx_r;
    tail_idx_nxt = tail_idx_r;
    dcnt_nxt     = dcnt_r;
    rem_nxt      = rem_r;
    prd_idx_nxt  = prd_idx_r;
    pwr_idx_nxt  = pwr_idx_r;
    pcnt_nxt     = pcnt_r;
    if (cmd.commit) begin
      if (cmd.desc_push) begin
        tail_idx_nxt = tail_inc;
        dcnt_nxt     = dcnt_r + 1'b1;
      end
      if (cmd.head_finish) begin
        head_idx_nxt = head_inc;
        dcnt_nxt     = dcnt_r - 1'b1;
      end
      if (cmd.pay_push) begin
        pwr_idx_nxt = pwr_inc;
        pcnt_nxt    = pcnt_r + 1'b1;
      end
      if (cmd.pay_pop) begin
        prd_idx_nxt = prd_inc;
        pcnt_nxt    = pcnt_r - 1'b1;
      end
      // Reload length on finish, load on first queue, else count down
      if (cmd.head_finish) begin
        rem_nxt = st.desc_last ? 8'd0 : dnext_q_r[15:8];
      end else if (cmd.rem_load) begin
        rem_nxt = item_r.byte_count;
      end else if (cmd.rem_dec && (rem_r != 8'd0)) begin
        rem_nxt = rem_r - 8'd1;
      end
    end
  end

  // Assemble the result
  always_comb begin
    out_nxt                  = '0;
    out_nxt.accepted         = cmd.accepted;
    out_nxt.issue_command    = cmd.issue;
    out_nxt.cmd_start        = cmd.start;
    out_nxt.cmd_stop         = cmd.stop;
    out_nxt.cmd_ack          = cmd.ack;
    out_nxt.read_valid       = cmd.rvalid;
    out_nxt.read_data        = cmd.rvalid ? item_r.data_byte : 8'd0;
    out_nxt.transaction_done = cmd.done;
    out_nxt.fault            = cmd.fault;
    case (cmd.wsel)
      WSEL_ADDR: begin
        out_nxt.write_data_valid = 1'b1;
        out_nxt.write_data       = {dhead_q_r[6:0], dhead_q_r[7]};
      end
      WSEL_PAY: begin
        out_nxt.write_data_valid = 1'b1;
        out_nxt.write_data       = pay_q_r;
      end
      default: begin
        out_nxt.write_data_valid = 1'b0;
        out_nxt.write_data       = 8'd0;
      end
    endcase
  end

  // Hold the result until the next commit
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_idx_r <= '0;
      tail_idx_r <= '0;
      dcnt_r     <= '0;
      rem_r      <= '0;
      prd_idx_r  <= '0;
      pwr_idx_r  <= '0;
      pcnt_r     <= '0;
    end else begin
      head_idx_r <= head_idx_nxt;
      tail_idx_r <= tail_idx_nxt;
      dcnt_r     <= dcnt_nxt;
      rem_r      <= rem_nxt;
      prd_idx_r  <= prd_idx_nxt;
      pwr_idx_r  <= pwr_idx_nxt;
      pcnt_r     <= pcnt_nxt;
    end
  end

  assign out_data = out_r;

  // Occupancy stays within the store sizes
  a_dcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= QC'(QUEUE_DEPTH))
    else $error("descriptor count above depth");

  a_pcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PC'(PAYLOAD_DEPTH))
    else $error("payload count above depth");

  // Empty queue means head and tail meet
  a_desc_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (dcnt_r == '0) |-> (head_idx_r == tail_idx_r))
    else $error("descriptor pointers out of step");

  a_pay_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (pcnt_r == '0) |-> (prd_idx_r == pwr_idx_r))
    else $error("payload pointers out of step");

endmodule

@@ rtl/i2cmtq_ctrl.sv @@
// ----------------------------------------------------------------------------
// I2C master transaction queue controller
// Handshake state machine and decode of each request into datapath commands.
// ----------------------------------------------------------------------------
module i2cmtq_ctrl
  import i2cmtq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Result slot is free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs: handshake and command decode
  always_comb begin
    logic do_finish;
    logic do_send;
    cmd       = '0;
    do_finish = 1'b0;
    do_send   = 1'b0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.commit = out_free;
        case (st.req)
          REQ_QWRITE, REQ_QREAD: begin
            if (!st.len_zero && !st.desc_full) begin
              cmd.desc_push = 1'b1;
              cmd.accepted  = 1'b1;
              // First transaction starts the bus at once
              if (st.desc_empty) begin
                cmd.rem_load = 1'b1;
                cmd.issue    = 1'b1;
                cmd.start    = 1'b1;
                cmd.ack      = 1'b1;
              end
            end
          end
          REQ_PUSH: begin
            if (!st.pay_full) begin
              cmd.pay_push = 1'b1;
              cmd.accepted = 1'b1;
            end
          end
          REQ_EVENT: begin
            if (!st.desc_empty) begin
              if (st.code == ST_START[7:3] || st.code == ST_RSTART[7:3]) begin
                cmd.wsel  = WSEL_ADDR;
                cmd.issue = 1'b1;
                cmd.ack   = 1'b1;
              end else if (!st.head_rd) begin
                // Write transaction
                if (st.code == ST_MT_DATA_ACK[7:3] ||
                    st.code == ST_MT_DATA_NACK[7:3]) begin
                  cmd.rem_dec = 1'b1;
                  if (st.rem_le1) begin
                    do_finish = 1'b1;
                  end else begin
                    do_send = 1'b1;
                  end
                end else if (st.code == ST_MT_SLA_ACK[7:3] ||
                             st.code == ST_MT_SLA_NACK[7:3]) begin
                  do_send = 1'b1;
                end else begin
                  cmd.fault = 1'b1;
                end
              end else begin
                // Read transaction
                if (st.code == ST_MR_DATA_ACK[7:3]) begin
                  cmd.rvalid  = 1'b1;
                  cmd.rem_dec = 1'b1;
                  cmd.issue   = 1'b1;
                  cmd.ack     = !st.rem_le2;
                end else if (st.code == ST_MR_SLA_ACK[7:3]) begin
                  cmd.issue = 1'b1;
                  cmd.ack   = !st.rem_le1;
                end else if (st.code == ST_MR_DATA_NACK[7:3]) begin
                  cmd.rvalid = 1'b1;
                  do_finish  = 1'b1;
                end else begin
                  cmd.fault = 1'b1;
                end
              end
            end
          end
          default: ;
        endcase
        // Drop the head: stop, or stop then start when more is queued
        if (do_finish) begin
          cmd.head_finish = 1'b1;
          cmd.done        = 1'b1;
          cmd.issue       = 1'b1;
          cmd.stop        = 1'b1;
          cmd.start       = !st.desc_last;
          cmd.ack         = 1'b1;
        end
        // Send the next payload byte, fault on underrun
        if (do_send) begin
          if (st.pay_empty) begin
            cmd.fault = 1'b1;
          end else begin
            cmd.pay_pop = 1'b1;
            cmd.wsel    = WSEL_PAY;
            cmd.issue   = 1'b1;
            cmd.ack     = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Result valid: set on commit, clear once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  // A fault never comes with a command
  a_fault_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && cmd.fault) |-> !cmd.issue)
    else $error("command issued together with fault");

  // Each commit is followed by a visible result
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

endmodule

@@ rtl/i2c_master_transaction_queue_top.sv @@
// ----------------------------------------------------------------------------
// I2C master transaction queue
// Queues write and read transactions and payload bytes, and turns each bus
// status event into the next engine command.
//
//   Channel  Direction  Ports                              Payload
//   in       input      in_valid, in_stall, in_data        in_req_t
//   out      output     out_valid, out_stall, out_data     out_res_t
//
// Each request is first captured, with the descriptor and payload memories
// read, and is then decoded and its result committed.
// A result is held in an output register; the next request is taken while
// it waits, but its commit waits until the register is free.
// Reset is synchronous, active low, and empties both queues at once.
// ----------------------------------------------------------------------------
module i2c_master_transaction_queue_top
  import i2cmtq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
  parameter int PAYLOAD_DEPTH = DEF_PAYLOAD_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_data
);

  cmd_t    cmd;
  status_t st;

  // Sequencing and decode
  i2cmtq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Queues, counters and result register
  i2cmtq_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

endmodule

@@ tb/tb_i2c_master_transaction_queue_top.sv @@
// ----------------------------------------------------------------------------
// I2C master transaction queue testbench
// Drives queue, push and bus status requests into the block, predicts every
// result with a cycle-free model of the descriptor store and payload FIFO,
// and compares each result field by field. A short directed opening covers
// the corner cases. Random episodes follow: well-formed transaction batches,
// mangled batches, noise and store floods. Both sides idle at random, and
// the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_i2c_master_transaction_queue_top;
  import i2cmtq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QD             = DEF_QUEUE_DEPTH;
  localparam int PD             = DEF_PAYLOAD_DEPTH;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PRESSURE_AT    = 400;
  localparam int PRESSURE_LEN   = 300;

  // Status codes with no handler in the block
  localparam logic [7:0] ST_ARB_LOST     = 8'h38;
  localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
  localparam logic [7:0] ST_NO_INFO      = 8'hF8;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_data;

  i2c_master_transaction_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Predicted block state
  logic [15:0] desc_mem [QD];
  int          desc_head = 0;
  int          desc_tail = 0;
  int          desc_used = 0;
  int          head_left = 0;
  logic [7:0]  pay_mem [PD];
  int          pay_rd = 0;
  int          pay_wr = 0;
  int          pay_used = 0;

  in_req_t  request_backlog[$];
  in_req_t  episode_reqs[$];
  out_res_t pending_responses[$];
  out_res_t want;

  int mismatches   = 0;
  int item_total   = 0;
  int results_seen = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int tx_calm      = 0;
  int rx_calm      = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Result prediction
  // ---------------------------------------------------------------------------
  function automatic void give_cmd(inout out_res_t o, input logic st, input logic sp,
                                   input logic ak);
    o.issue_command = 1'b1;
    o.cmd_start     = st;
    o.cmd_stop      = sp;
    o.cmd_ack       = ak;
  endfunction

  // Drop the head transaction; stop, or stop then start on the next one
  function automatic void retire_head(inout out_res_t o);
    desc_head = (desc_head + 1) % QD;
    desc_used--;
    o.transaction_done = 1'b1;
    if (desc_used == 0) begin
      head_left = 0;
      give_cmd(o, 1'b0, 1'b1, 1'b1);
    end else begin
      head_left = desc_mem[desc_head][15:8];
      give_cmd(o, 1'b1, 1'b1, 1'b1);
    end
  endfunction

  // Load the next payload byte, or flag an underrun
  function automatic void load_payload(inout out_res_t o);
    if (pay_used == 0) begin
      o.fault = 1'b1;
    end else begin
      o.write_data_valid = 1'b1;
      o.write_data       = pay_mem[pay_rd];
      pay_rd             = (pay_rd + 1) % PD;
      pay_used--;
      give_cmd(o, 1'b0, 1'b0, 1'b1);
    end
  endfunction

  function automatic out_res_t bus_response(in_req_t r);
    out_res_t   o;
    logic [7:0] code;
    logic [15:0] d;
    logic       rd;
    o    = '0;
    code = r.bus_status & 8'hF8;
    if (r.req_type == REQ_QWRITE || r.req_type == REQ_QREAD) begin
      if (r.byte_count != 8'd0 && desc_used < QD) begin
        desc_mem[desc_tail] = {r.byte_count, r.req_type[0], r.dev_addr};
        desc_tail  = (desc_tail + 1) % QD;
        o.accepted = 1'b1;
        if (desc_used == 0) begin
          head_left = r.byte_count;
          give_cmd(o, 1'b1, 1'b0, 1'b1);
        end
        desc_used++;
      end
    end else if (r.req_type == REQ_PUSH) begin
      if (pay_used < PD) begin
        pay_mem[pay_wr] = r.data_byte;
        pay_wr     = (pay_wr + 1) % PD;
        pay_used++;
        o.accepted = 1'b1;
      end
    end else if (desc_used != 0) begin
      d  = desc_mem[desc_head];
      rd = d[7];
      if (code == ST_START || code == ST_RSTART) begin
        o.write_data_valid = 1'b1;
        o.write_data       = {d[6:0], rd};
        give_cmd(o, 1'b0, 1'b0, 1'b1);
      end else if (!rd) begin
        if (code == ST_MT_DATA_ACK || code == ST_MT_DATA_NACK) begin
          if (head_left != 0) head_left--;
          if (head_left == 0) retire_head(o);
          else load_payload(o);
        end else if (code == ST_MT_SLA_ACK || code == ST_MT_SLA_NACK) begin
          load_payload(o);
        end else begin
          o.fault = 1'b1;
        end
      end else begin
        if (code == ST_MR_DATA_ACK || code == ST_MR_SLA_ACK) begin
          if (code == ST_MR_DATA_ACK) begin
            o.read_valid = 1'b1;
            o.read_data  = r.data_byte;
            if (head_left != 0) head_left--;
          end
          give_cmd(o, 1'b0, 1'b0, head_left > 1);
        end else if (code == ST_MR_DATA_NACK) begin
          o.read_valid = 1'b1;
          o.read_data  = r.data_byte;
          retire_head(o);
        end else begin
          o.fault = 1'b1;
        end
      end
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // Idle count for the next request or stall; calm stretches give zero
  function automatic int pick_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(20, 80);
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [7:0] listed_code();
    case ($urandom_range(0, 11))
      0:       return ST_START;
      1:       return ST_RSTART;
      2:       return ST_MT_SLA_ACK;
      3:       return ST_MT_SLA_NACK;
      4:       return ST_MT_DATA_ACK;
      5:       return ST_MT_DATA_NACK;
      6:       return ST_ARB_LOST;
      7:       return ST_MR_SLA_ACK;
      8:       return ST_MR_SLA_NACK;
      9:       return ST_MR_DATA_ACK;
      10:      return ST_MR_DATA_NACK;
      default: return ST_NO_INFO;
    endcase
  endfunction

  function automatic in_req_t noise_request();
    in_req_t r;
    r.req_type       = 2'($urandom_range(0, 3));
    r.dev_addr       = 7'($urandom);
    r.byte_count     = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    r.data_byte      = 8'($urandom);
    r.bus_status     = $urandom_range(0, 1) ? 8'($urandom)
                                            : (listed_code() | 8'($urandom_range(0, 7)));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Episode building
  // ---------------------------------------------------------------------------
  task automatic add_event(logic [7:0] code, int unsigned data);
    in_req_t r;
    r.req_type       = REQ_EVENT;
    r.dev_addr       = 7'($urandom);
    r.byte_count     = 8'($urandom);
    r.data_byte      = 8'(data);
    r.bus_status     = code | 8'($urandom_range(0, 7));
    episode_reqs.push_back(r);
  endtask

  task automatic add_push(int unsigned data);
    in_req_t r;
    r.req_type       = REQ_PUSH;
    r.dev_addr       = 7'($urandom);
    r.byte_count     = 8'($urandom);
    r.data_byte      = 8'(data);
    r.bus_status     = 8'($urandom);
    episode_reqs.push_back(r);
  endtask

  task automatic add_queue(req_t kind, int unsigned addr, int unsigned len);
    in_req_t r;
    r.req_type       = kind;
    r.dev_addr       = 7'(addr);
    r.byte_count     = 8'(len);
    r.data_byte      = 8'($urandom);
    r.bus_status     = 8'($urandom);
    episode_reqs.push_back(r);
  endtask

  task automatic flush_episode();
    foreach (episode_reqs[i]) request_backlog.push_back(episode_reqs[i]);
    item_total += episode_reqs.size();
    episode_reqs.delete();
  endtask

  // Wait until every request handed to the driver has been accepted
  task automatic wait_input_idle();
    @(posedge clk);
    #1;
    while (request_backlog.size() != 0 || in_valid) begin
      @(posedge clk);
      #1;
    end
  endtask

  // One to three transactions with their payload and the full event sequence
  task automatic build_batch();
    int         n;
    bit         is_rd [3];
    logic [7:0] len [3];
    n = $urandom_range(1, 3);
    for (int k = 0; k < n; k++) begin
      is_rd[k] = 1'($urandom_range(0, 1));
      len[k]   = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(5, 16)
                                                : $urandom_range(1, 4));
      if (!is_rd[k]) repeat (len[k]) add_push($urandom);
    end
    for (int k = 0; k < n; k++)
      add_queue(is_rd[k] ? REQ_QREAD : REQ_QWRITE, $urandom, len[k]);
    for (int k = 0; k < n; k++) begin
      add_event((k == 0 || $urandom_range(0, 1)) ? ST_START : ST_RSTART, $urandom);
      if (!is_rd[k]) begin
        add_event($urandom_range(0, 1) ? ST_MT_SLA_ACK : ST_MT_SLA_NACK, $urandom);
        repeat (len[k])
          add_event($urandom_range(0, 1) ? ST_MT_DATA_ACK : ST_MT_DATA_NACK, $urandom);
      end else begin
        add_event(ST_MR_SLA_ACK, $urandom);
        repeat (len[k] - 1) add_event(ST_MR_DATA_ACK, $urandom);
        add_event(ST_MR_DATA_NACK, $urandom);
      end
    end
  endtask

  // Break a batch: drop, insert noise, or repeat a request
  task automatic mangle_episode();
    int idx;
    repeat ($urandom_range(1, 3)) begin
      if (episode_reqs.size() != 0) begin
        idx = $urandom_range(0, episode_reqs.size() - 1);
        case ($urandom_range(0, 2))
          0:       episode_reqs.delete(idx);
          1:       episode_reqs.insert(idx, noise_request());
          default: episode_reqs.insert(idx, episode_reqs[idx]);
        endcase
      end
    end
  endtask

  // Fill the descriptor store and the payload FIFO past their depth
  task automatic build_flood();
    add_queue(REQ_QREAD, $urandom, 0);
    repeat (QD + 1) add_queue(REQ_QREAD, $urandom, $urandom_range(1, 3));
    repeat (PD + 1) add_push($urandom);
    add_event(ST_START, $urandom);
  endtask

  // Bring the predicted state back to empty queues with well-formed traffic
  task automatic resync();
    int steps;
    while (desc_used != 0 || pay_used != 0) begin
      if (desc_used != 0) begin
        if (desc_mem[desc_head][7]) begin
          add_event(ST_MR_DATA_NACK, $urandom);
        end else begin
          steps = (head_left == 0) ? 1 : head_left;
          repeat (steps) add_event(ST_MT_DATA_ACK, $urandom);
        end
      end else begin
        steps = pay_used;
        add_queue(REQ_QWRITE, $urandom, unsigned'(steps));
        add_event(ST_START, $urandom);
        add_event(ST_MT_SLA_ACK, $urandom);
        repeat (steps) add_event(ST_MT_DATA_ACK, $urandom);
      end
      flush_episode();
      wait_input_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Request driver: hold while stalled, idle between requests, predict on accept
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) pending_responses.push_back(bus_response(in_data));
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          in_data  <= request_backlog.pop_front();
          in_valid <= 1'b1;
          gap_left = pick_wait(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare with the oldest prediction, then stall at random
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_responses.size() == 0) begin
          $error("result with no request waiting for it");
          mismatches++;
        end else begin
          want = pending_responses.pop_front();
          check_field("accepted", want.accepted, out_data.accepted);
          check_field("issue_command", want.issue_command, out_data.issue_command);
          check_field("cmd_start", want.cmd_start, out_data.cmd_start);
          check_field("cmd_stop", want.cmd_stop, out_data.cmd_stop);
          check_field("cmd_ack", want.cmd_ack, out_data.cmd_ack);
          check_field("write_data_valid", want.write_data_valid, out_data.write_data_valid);
          check_field("write_data", want.write_data, out_data.write_data);
          check_field("read_valid", want.read_valid, out_data.read_valid);
          check_field("read_data", want.read_data, out_data.read_data);
          check_field("transaction_done", want.transaction_done, out_data.transaction_done);
          check_field("fault", want.fault, out_data.fault);
        end
        stall_left = pick_wait(rx_calm);
        // Hold off long enough to back the block up into its input
        if (results_seen == PRESSURE_AT) stall_left = PRESSURE_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles with no request or result moving
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int directed_items;
    int pick;
    while (!rst_n) @(posedge clk);

    // Corner cases: empty queue, refusals, both transaction kinds, faults,
    // underrun, stop then start, maximum-length read ended by a NACK
    add_event(ST_MT_SLA_ACK, $urandom);
    add_queue(REQ_QWRITE, 7'h7F, 8'd0);
    add_queue(REQ_QREAD, 7'h00, 8'd0);
    add_push(8'hFF);
    add_push(8'h00);
    add_queue(REQ_QWRITE, 7'h7F, 8'd2);
    add_event(ST_START, $urandom);
    add_event(ST_MT_SLA_ACK, $urandom);
    add_event(ST_ARB_LOST, $urandom);
    add_event(ST_MT_DATA_ACK, $urandom);
    add_event(ST_NO_INFO, $urandom);
    add_event(ST_MT_DATA_NACK, $urandom);
    add_queue(REQ_QREAD, 7'h00, 8'd2);
    add_queue(REQ_QWRITE, 7'h55, 8'd1);
    add_event(ST_START, $urandom);
    add_event(ST_MR_SLA_NACK, $urandom);
    add_event(ST_MR_SLA_ACK, $urandom);
    add_event(ST_MR_DATA_ACK, 8'hFF);
    add_event(ST_MR_DATA_NACK, 8'h00);
    add_event(ST_RSTART, $urandom);
    add_event(ST_MT_SLA_NACK, $urandom);
    add_event(ST_MT_DATA_ACK, $urandom);
    add_queue(REQ_QREAD, 7'h2A, 8'hFF);
    add_event(ST_MR_DATA_ACK, $urandom);
    add_event(ST_MR_DATA_NACK, $urandom);
    flush_episode();
    wait_input_idle();
    directed_items = item_total;

    // Random episodes, each starting from empty queues
    while (item_total < directed_items + RANDOM_ITEMS) begin
      resync();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        build_batch();
      end else if (pick < 83) begin
        build_batch();
        mangle_episode();
      end else if (pick < 98) begin
        repeat ($urandom_range(1, 8)) episode_reqs.push_back(noise_request());
      end else begin
        build_flood();
      end
      flush_episode();
      wait_input_idle();
    end

    // Drain every outstanding result, then allow for stray ones
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_responses.size() != 0) begin
      $error("%0d predicted results never arrived", pending_responses.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/i2cmtq_pkg.sv
rtl/i2cmtq_dp.sv
rtl/i2cmtq_ctrl.sv
rtl/i2c_master_transaction_queue_top.sv
tb/tb_i2c_master_transaction_queue_top.sv
